### hw/rtl/crr_pkg.sv
// crr_pkg: shared sizes, command codes, item and range-entry types for the
// chained range remap block. no dependencies; used by all rtl but crr_ram.
package crr_pkg;

   // chain and table sizes
   localparam int STAGES  = 7;
   localparam int ENTRIES = 128;
   localparam int DEPTH   = STAGES * ENTRIES;

   // derived widths
   localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int ACT_W   = $clog2(STAGES + 1);
   localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_W  = $clog2(ENTRIES + 1);
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // fixed field widths
   localparam int FUNC_W = 2;
   localparam int SEL_W  = 3;
   localparam int DATA_W = 64;
   localparam int USE_W  = 3;

   // stages applied after reset
   localparam logic [USE_W-1:0] USE_RESET = 3'd7;

   // function codes on the request channel
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   // decoded command handed from front to back
   typedef enum logic [1:0] {
      CMD_APPEND,
      CMD_QUERY,
      CMD_CLEAR
   } cmd_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EMIT
   } back_state_type;

   // one queued command: for an append a = offset, b = source, c = length;
   // for a query b carries the value
   typedef struct packed {
      cmd_type                cmd;
      logic [STAGE_W-1:0]     stage;
      logic [DATA_W-1:0]      a;
      logic [DATA_W-1:0]      b;
      logic [DATA_W-1:0]      c;
   } item_type;

   // one stored range: offset (dst - src), source base and length
   typedef struct packed {
      logic [DATA_W-1:0] off;
      logic [DATA_W-1:0] src;
      logic [DATA_W-1:0] len;
   } entry_type;

   // flat table address of entry i in stage s
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [STAGE_W-1:0] s,
                                                     input logic [ENTRY_W-1:0] i);
      return ADDR_W'(ADDR_W'(s) * ADDR_W'(ENTRIES)) + ADDR_W'(i);
   endfunction

endpackage

### hw/rtl/crr_ram.sv
// crr_ram: generic single write port, single read port ram with registered
// read data. no package dependency.
module crr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/crr_front.sv
// crr_front: accepts request beats, decodes and filters them, and holds
// them in a short command queue for the back end. uses crr_pkg.
module crr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [crr_pkg::FUNC_W-1:0]    req_func,
   input  logic [crr_pkg::SEL_W-1:0]     req_stage_sel,
   input  logic [crr_pkg::DATA_W-1:0]    req_dst_base,
   input  logic [crr_pkg::DATA_W-1:0]    req_src_base,
   input  logic [crr_pkg::DATA_W-1:0]    req_span_len,
   input  logic [crr_pkg::DATA_W-1:0]    req_query_value,
   output crr_pkg::item_type             head,
   output logic                          head_valid,
   input  logic                          head_take
);
   import crr_pkg::*;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   item_type            q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                accept;
   logic                keep;
   logic                do_wr;
   logic                do_rd;
   item_type            dec;

   assign req_full   = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = q_ff[rd_ptr_ff];
   assign accept     = req_push && !req_full;

   // decode the beat; unused codes and appends to missing stages are dropped
   always_comb begin
      dec       = '0;
      keep      = 1'b0;
      case (req_func)
         FUNC_APPEND: begin
            dec.cmd   = CMD_APPEND;
            dec.stage = STAGE_W'(req_stage_sel);
            dec.a     = req_dst_base - req_src_base;
            dec.b     = req_src_base;
            dec.c     = req_span_len;
            keep      = (32'(req_stage_sel) < STAGES);
         end
         FUNC_QUERY: begin
            dec.cmd = CMD_QUERY;
            dec.b   = req_query_value;
            keep    = 1'b1;
         end
         FUNC_CLEAR: begin
            dec.cmd = CMD_CLEAR;
            keep    = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // queue pointer and count update
   always_comb begin
      do_wr     = accept && keep;
      do_rd     = head_take && head_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (!do_wr && do_rd) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule

### hw/rtl/crr_back.sv
// crr_back: executes queued commands: appends into the range table, walks
// the stages for a query one range per cycle, keeps the minimum and holds
// the result beat. uses crr_pkg and crr_ram.
module crr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  crr_pkg::item_type             head,
   input  logic                          head_valid,
   output logic                          head_take,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [crr_pkg::USE_W-1:0]     csr_stages_in_use,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [crr_pkg::DATA_W-1:0]    rsp_mapped_result,
   output logic [crr_pkg::DATA_W-1:0]    rsp_min_so_far
);
   import crr_pkg::*;

   back_state_type       state_ff, state_in;
   logic [STAGE_W-1:0]   stage_ff, stage_in;
   logic [ACT_W-1:0]     active_ff, active_in;
   logic [FILL_W-1:0]    idx_ff, idx_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [DATA_W-1:0]    x_ff, x_in;
   logic [DATA_W-1:0]    min_ff, min_in;
   logic [FILL_W-1:0]    fill_ff [STAGES];
   logic [FILL_W-1:0]    fill_in [STAGES];
   logic [USE_W-1:0]     use_ff, use_in;
   logic                 out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]    out_x_ff, out_x_in;
   logic [DATA_W-1:0]    out_min_ff, out_min_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   entry_type            wr_entry;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   entry_type            rd_entry;
   logic [FILL_W-1:0]    fill_cur;
   logic [DATA_W-1:0]    diff;
   logic                 hit;
   logic                 stage_done;
   logic                 last_stage;

   assign csr_ready         = 1'b1;
   assign rsp_empty         = !out_valid_ff;
   assign rsp_mapped_result = out_x_ff;
   assign rsp_min_so_far    = out_min_ff;

   // range table, one entry read per cycle
   crr_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // range test on the entry read last cycle
   assign fill_cur   = fill_ff[stage_ff];
   assign diff       = x_ff - rd_entry.src;
   assign hit        = rd_valid_ff && (x_ff >= rd_entry.src) && (diff < rd_entry.len);
   assign stage_done = hit || ((idx_ff == fill_cur) && !rd_valid_ff);
   assign last_stage = ((32'(stage_ff) + 1) >= 32'(active_ff));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      rd_valid_in  = 1'b0;
      x_in         = x_ff;
      min_in       = min_ff;
      fill_in      = fill_ff;
      use_in       = csr_valid ? csr_stages_in_use : use_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_x_in     = out_x_ff;
      out_min_in   = out_min_ff;
      head_take    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = entry_addr(head.stage, fill_ff[head.stage][ENTRY_W-1:0]);
      wr_entry     = '{off: head.a, src: head.b, len: head.c};
      rd_en        = 1'b0;
      rd_addr      = entry_addr(stage_ff, idx_ff[ENTRY_W-1:0]);

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_take = 1'b1;
               case (head.cmd)
                  CMD_APPEND: begin
                     if (fill_ff[head.stage] < FILL_W'(ENTRIES)) begin
                        wr_en                = 1'b1;
                        fill_in[head.stage] = fill_ff[head.stage] + 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     x_in      = head.b;
                     stage_in  = '0;
                     idx_in    = '0;
                     active_in = (32'(use_ff) > STAGES) ? ACT_W'(STAGES)
                                                          : ACT_W'(use_ff);
                     state_in  = (use_ff == '0) ? ST_EMIT : ST_WALK;
                  end
                  CMD_CLEAR: begin
                     for (int s = 0; s < STAGES; s++) begin
                        fill_in[s] = '0;
                     end
                     min_in = '1;
                  end
                  default: begin
                     head_take = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // first hit in a stage maps the value and ends that stage
            if (hit) begin
               x_in = x_ff + rd_entry.off;
            end
            if (stage_done) begin
               idx_in = '0;
               if (last_stage) begin
                  state_in = ST_EMIT;
               end else begin
                  stage_in = stage_ff + 1'b1;
               end
            end else if (idx_ff < fill_cur) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               idx_in      = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_pop) begin
               min_in       = (x_ff < min_ff) ? x_ff : min_ff;
               out_valid_in = 1'b1;
               out_x_in     = x_ff;
               out_min_in   = (x_ff < min_ff) ? x_ff : min_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         min_ff       <= '1;
         use_ff       <= USE_RESET;
         out_valid_ff <= 1'b0;
         for (int s = 0; s < STAGES; s++) begin
            fill_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         min_ff       <= min_in;
         use_ff       <= use_in;
         out_valid_ff <= out_valid_in;
         fill_ff      <= fill_in;
      end
   end

   // walk and result payload
   always_ff @(posedge clock) begin
      stage_ff   <= stage_in;
      active_ff  <= active_in;
      idx_ff     <= idx_in;
      x_ff       <= x_in;
      out_x_ff   <= out_x_in;
      out_min_ff <= out_min_in;
   end
endmodule

### hw/rtl/chained_range_remap.sv
// chained_range_remap: top level of the chained range remap block.
// depends on crr_pkg, crr_front, crr_back (and crr_ram beneath it).
//
// usage:
//   request queue (req_push / req_full): each beat is an append of a range
//   to one stage, a query value, or a clear. appends to a stage outside the
//   chain, appends to a full stage and unused codes are dropped.
//   result queue (rsp_empty / rsp_pop): one beat per query with the mapped
//   value and the smallest mapped value since the last clear.
//   csr write channel (csr_valid / csr_ready, ready always high) sets how
//   many stages a query goes through; write it only while the block is idle.
// operation:
//   each beat is registered in the command queue; the back end takes an
//   append or a clear in its idle state and applies it to its table and
//   registers. a query walks the active stages in order, one range per
//   cycle through the single read port of the range table; a stage ends at
//   its first holding range or after its last range, and the emit state
//   then loads the result beat. commands run one at a time.
//   a two-beat command queue lets requests be taken while the back end works.
// reset: fill counts go to zero, the minimum to all ones and the stage count
//   to 7; the range table itself needs no clearing pass.
// stall: a finished result waits in the output register while rsp_pop is
//   low; the back end then stops at its next result and the queue fills.
module chained_range_remap (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [crr_pkg::FUNC_W-1:0]    req_func,
   input  logic [crr_pkg::SEL_W-1:0]     req_stage_sel,
   input  logic [crr_pkg::DATA_W-1:0]    req_dst_base,
   input  logic [crr_pkg::DATA_W-1:0]    req_src_base,
   input  logic [crr_pkg::DATA_W-1:0]    req_span_len,
   input  logic [crr_pkg::DATA_W-1:0]    req_query_value,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [crr_pkg::DATA_W-1:0]    rsp_mapped_result,
   output logic [crr_pkg::DATA_W-1:0]    rsp_min_so_far,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [crr_pkg::USE_W-1:0]     csr_stages_in_use
);
   import crr_pkg::*;

   item_type head;
   logic     head_valid;
   logic     head_take;

   // decode and queue
   crr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_stage_sel   (req_stage_sel),
      .req_dst_base    (req_dst_base),
      .req_src_base    (req_src_base),
      .req_span_len    (req_span_len),
      .req_query_value (req_query_value),
      .head            (head),
      .head_valid      (head_valid),
      .head_take       (head_take)
   );

   // execution
   crr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .head_valid        (head_valid),
      .head_take         (head_take),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_stages_in_use (csr_stages_in_use),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_mapped_result (rsp_mapped_result),
      .rsp_min_so_far    (rsp_min_so_far)
   );
endmodule

### hw/rtl/crr_checker.sv
// crr_checker: port-level checks on chained_range_remap, bound to the top
// level below. uses crr_pkg for widths.
module crr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_push,
   input logic                          req_full,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic [crr_pkg::DATA_W-1:0]    rsp_mapped_result,
   input logic [crr_pkg::DATA_W-1:0]    rsp_min_so_far
);
   // reset leaves the result queue empty and the request queue not full
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // the running minimum never exceeds the value it comes with
   a_min_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_min_so_far <= rsp_mapped_result))
      else $error("minimum above mapped result");

   // a waiting result beat holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_mapped_result) && $stable(rsp_min_so_far)))
      else $error("result beat changed while waiting");

   // the request queue fills only after a beat was pushed
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("request queue full without a push");
endmodule

bind chained_range_remap crr_checker u_crr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_push          (req_push),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_mapped_result (rsp_mapped_result),
   .rsp_min_so_far    (rsp_min_so_far)
);

### tb/remap_checker.sv
`timescale 1ns / 1ps
// remap_checker: watches the request, result and csr channels of chained_range_remap,
// keeps its own copy of the range tables and checks every result beat field by field.
// depends on crr_pkg for widths, sizes and function codes.
module remap_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  logic                       req_full,
   input  logic [crr_pkg::FUNC_W-1:0] req_func,
   input  logic [crr_pkg::SEL_W-1:0]  req_stage_sel,
   input  logic [crr_pkg::DATA_W-1:0] req_dst_base,
   input  logic [crr_pkg::DATA_W-1:0] req_src_base,
   input  logic [crr_pkg::DATA_W-1:0] req_span_len,
   input  logic [crr_pkg::DATA_W-1:0] req_query_value,
   input  logic                       rsp_empty,
   input  logic                       rsp_pop,
   input  logic [crr_pkg::DATA_W-1:0] rsp_mapped_result,
   input  logic [crr_pkg::DATA_W-1:0] rsp_min_so_far,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [crr_pkg::USE_W-1:0]  csr_stages_in_use,
   output int                         mismatch_count,
   output int                         owed_count
);
   import crr_pkg::*;

   // one expected result beat
   typedef struct packed {
      logic [DATA_W-1:0] mapped;
      logic [DATA_W-1:0] lowest;
   } map_answer_type;

   // mirror of the range tables, fill counts, minimum and stage count
   logic [DATA_W-1:0] tbl_dst [DEPTH];
   logic [DATA_W-1:0] tbl_src [DEPTH];
   logic [DATA_W-1:0] tbl_len [DEPTH];
   int unsigned       tbl_fill [STAGES];
   logic [DATA_W-1:0] low_mark;
   logic [USE_W-1:0]  chain_len;
   map_answer_type    owed_maps [$];

   // pass a value through the active stages, first holding range wins
   function automatic logic [DATA_W-1:0] chain_remap(input logic [DATA_W-1:0] x);
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] nv;
      int                active;
      int                a;
      bit                hit;
      v = x;
      nv = x;
      active = (int'(chain_len) > STAGES) ? STAGES : int'(chain_len);
      for (int s = 0; s < active; s++) begin
         hit = 1'b0;
         for (int i = 0; i < int'(tbl_fill[s]); i++) begin
            a = s * ENTRIES + i;
            // exact test, no wrap of src + len
            if (!hit && v >= tbl_src[a] && (v - tbl_src[a]) < tbl_len[a]) begin
               nv = v + (tbl_dst[a] - tbl_src[a]);
               hit = 1'b1;
            end
         end
         if (hit) v = nv;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      map_answer_type    want;
      logic [DATA_W-1:0] v;
      int                a;
      if (reset) begin
         foreach (tbl_fill[s]) tbl_fill[s] = 0;
         low_mark = '1;
         chain_len = USE_RESET;
         owed_maps.delete();
      end else begin
         // result beat first: it always belongs to an earlier query
         if (rsp_pop && !rsp_empty) begin
            if (owed_maps.size() == 0) begin
               $error("result beat with no query owing: mapped_result %h min_so_far %h",
                      rsp_mapped_result, rsp_min_so_far);
               mismatch_count++;
            end else begin
               want = owed_maps.pop_front();
               if (rsp_mapped_result !== want.mapped) begin
                  $error("mapped_result expected %h actual %h", want.mapped, rsp_mapped_result);
                  mismatch_count++;
               end
               if (rsp_min_so_far !== want.lowest) begin
                  $error("min_so_far expected %h actual %h", want.lowest, rsp_min_so_far);
                  mismatch_count++;
               end
            end
         end

         // stage count write
         if (csr_valid && csr_ready) chain_len = csr_stages_in_use;

         // request beat
         if (req_push && !req_full) begin
            case (req_func)
               FUNC_APPEND: begin
                  // out of range stage or full stage is dropped
                  if (int'(req_stage_sel) < STAGES) begin
                     if (tbl_fill[req_stage_sel] < ENTRIES) begin
                        a = int'(req_stage_sel) * ENTRIES + int'(tbl_fill[req_stage_sel]);
                        tbl_dst[a] = req_dst_base;
                        tbl_src[a] = req_src_base;
                        tbl_len[a] = req_span_len;
                        tbl_fill[req_stage_sel]++;
                     end
                  end
               end
               FUNC_QUERY: begin
                  v = chain_remap(req_query_value);
                  if (v < low_mark) low_mark = v;
                  owed_maps.push_back('{mapped: v, lowest: low_mark});
               end
               FUNC_CLEAR: begin
                  // ranges stay in the table but become unreachable
                  foreach (tbl_fill[s]) tbl_fill[s] = 0;
                  low_mark = '1;
               end
               default: ;
            endcase
         end
      end
      owed_count <= owed_maps.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: clock, reset, stimulus and verdict for chained_range_remap; prediction and
// comparison live in remap_checker. depends on crr_pkg, chained_range_remap, remap_checker.
module tb_top;
   import crr_pkg::*;

   localparam int ITEM_GOAL     = 660;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 32;

   // code the block leaves unused
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   logic [FUNC_W-1:0] req_func;
   logic [SEL_W-1:0]  req_stage_sel;
   logic [DATA_W-1:0] req_dst_base;
   logic [DATA_W-1:0] req_src_base;
   logic [DATA_W-1:0] req_span_len;
   logic [DATA_W-1:0] req_query_value;
   logic              rsp_empty;
   logic              rsp_pop;
   logic [DATA_W-1:0] rsp_mapped_result;
   logic [DATA_W-1:0] rsp_min_so_far;
   logic              csr_valid;
   logic              csr_ready;
   logic [USE_W-1:0]  csr_stages_in_use;
   int                mismatch_count;
   int                owed_count;
   int                req_calm;
   int                rsp_calm;
   int                cycle_count;

   chained_range_remap dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_func          (req_func),
      .req_stage_sel     (req_stage_sel),
      .req_dst_base      (req_dst_base),
      .req_src_base      (req_src_base),
      .req_span_len      (req_span_len),
      .req_query_value   (req_query_value),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_mapped_result (rsp_mapped_result),
      .rsp_min_so_far    (rsp_min_so_far),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_stages_in_use (csr_stages_in_use)
   );

   remap_checker chk (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_func          (req_func),
      .req_stage_sel     (req_stage_sel),
      .req_dst_base      (req_dst_base),
      .req_src_base      (req_src_base),
      .req_span_len      (req_span_len),
      .req_query_value   (req_query_value),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_mapped_result (rsp_mapped_result),
      .rsp_min_so_far    (rsp_min_so_far),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_stages_in_use (csr_stages_in_use),
      .mismatch_count    (mismatch_count),
      .owed_count        (owed_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic logic [DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // idle cycles before a beat, with calm stretches of back to back beats
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   // one request beat; push stays high when the next beat follows at once
   task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [SEL_W-1:0] sel,
                            input logic [DATA_W-1:0] dst, input logic [DATA_W-1:0] src,
                            input logic [DATA_W-1:0] span, input logic [DATA_W-1:0] qval);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_func        <= func;
      req_stage_sel   <= sel;
      req_dst_base    <= dst;
      req_src_base    <= src;
      req_span_len    <= span;
      req_query_value <= qval;
      do @(posedge clock); while (req_full);
   endtask

   // stage count write once every result is in and the block has settled
   task automatic set_chain_len(input logic [USE_W-1:0] n);
      req_push <= 1'b0;
      @(posedge clock);
      wait (owed_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_stages_in_use <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // dropped beats: unused code or a stage outside the chain
   task automatic send_noise();
      if ($urandom_range(0, 1) == 0)
         send_beat(FUNC_UNUSED, SEL_W'($urandom), rand64(), rand64(), rand64(), rand64());
      else
         send_beat(FUNC_APPEND, SEL_W'(STAGES), rand64(), rand64(), rand64(), rand64());
   endtask

   // range mostly inside a 4k window so that chained stages hand values on
   task automatic append_window_range(input logic [SEL_W-1:0] sel,
                                      input logic [DATA_W-1:0] base);
      logic [DATA_W-1:0] src;
      logic [DATA_W-1:0] dst;
      logic [DATA_W-1:0] span;
      src  = base + DATA_W'($urandom_range(0, 3000));
      dst  = base + DATA_W'($urandom_range(0, 3000));
      span = DATA_W'($urandom_range(1, 600));
      case ($urandom_range(0, 11))
         0: span = '0;
         1: span = rand64();
         2: dst = rand64();
         3: src = rand64();
         default: ;
      endcase
      send_beat(FUNC_APPEND, sel, dst, src, span, rand64());
   endtask

   // result side
   initial begin
      int gap;
      rsp_pop  = 1'b0;
      rsp_calm = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   // stimulus and verdict
   initial begin
      logic [DATA_W-1:0] all_ones;
      logic [DATA_W-1:0] window;
      logic [DATA_W-1:0] qval;
      logic [USE_W-1:0]  n;
      logic [SEL_W-1:0]  full_sel;
      int                items_sent;
      int                phase;
      int                cnt;
      all_ones          = '1;
      reset             = 1'b1;
      req_push          = 1'b0;
      req_func          = FUNC_APPEND;
      req_stage_sel     = '0;
      req_dst_base      = '0;
      req_src_base      = '0;
      req_span_len      = '0;
      req_query_value   = '0;
      csr_valid         = 1'b0;
      csr_stages_in_use = USE_RESET;
      req_calm          = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tables pass values through
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, all_ones);
      send_beat(FUNC_QUERY, 3'd6, all_ones, all_ones, all_ones, '0);
      send_beat(FUNC_CLEAR, 3'd0, '0, '0, '0, '0);
      // first holding range wins over a later overlapping one
      send_beat(FUNC_APPEND, 3'd0, 64'd100, 64'd10, 64'd5, '0);
      send_beat(FUNC_APPEND, 3'd0, 64'd500, 64'd10, 64'd20, '0);
      // zero length range holds nothing
      send_beat(FUNC_APPEND, 3'd1, 64'd7, 64'd20, 64'd0, '0);
      // range whose end passes the top of the value space
      send_beat(FUNC_APPEND, 3'd2, '0, 64'hFFFF_FFFF_FFFF_FFF0, all_ones, '0);
      send_beat(FUNC_APPEND, 3'd6, all_ones, '0, 64'd1, '0);
      // stage outside the chain and unused code
      send_beat(FUNC_APPEND, SEL_W'(STAGES), 64'd1, 64'd0, all_ones, '0);
      send_beat(FUNC_UNUSED, 3'd7, all_ones, all_ones, all_ones, all_ones);
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, 64'd10);
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, 64'd14);
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, 64'd15);
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, 64'd9);
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, 64'd20);
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, all_ones);
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, '0);
      // no stages, then one stage
      set_chain_len(3'd0);
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, 64'd10);
      set_chain_len(3'd1);
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, 64'd12);
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, all_ones);
      // clear keeps the stage count
      send_beat(FUNC_CLEAR, 3'd0, '0, '0, '0, '0);
      send_beat(FUNC_QUERY, 3'd0, '0, '0, '0, 64'd12);

      // random phases: clear, fill stages with ranges, then query
      items_sent = 0;
      phase      = 0;
      while (items_sent < ITEM_GOAL) begin
         case (phase)
            0: n = 3'd7;
            1: n = 3'd0;
            2: n = 3'd1;
            default: n = USE_W'($urandom_range(0, 7));
         endcase
         set_chain_len(n);
         send_beat(FUNC_CLEAR, SEL_W'($urandom), rand64(), rand64(), rand64(), rand64());
         items_sent++;

         case (phase % 4)
            0: window = '0;
            1: window = all_ones - DATA_W'(4095);
            default: window = rand64();
         endcase

         // one phase overfills a stage; the extra appends are dropped
         if (phase == 3) begin
            full_sel = SEL_W'($urandom_range(0, STAGES - 1));
            for (int k = 0; k < ENTRIES + 3; k++) append_window_range(full_sel, window);
            items_sent += ENTRIES;
         end

         for (int s = 0; s < STAGES; s++) begin
            cnt = $urandom_range(0, 5);
            for (int k = 0; k < cnt; k++) begin
               if ($urandom_range(0, 19) == 0) send_noise();
               append_window_range(SEL_W'(s), window);
               items_sent++;
            end
         end

         cnt = $urandom_range(6, 18);
         for (int k = 0; k < cnt; k++) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            // late appends between queries
            if ($urandom_range(0, 9) == 0) begin
               append_window_range(SEL_W'($urandom_range(0, STAGES - 1)), window);
               items_sent++;
            end
            case ($urandom_range(0, 15))
               0: qval = '0;
               1: qval = all_ones;
               2, 3: qval = rand64();
               default: qval = window + DATA_W'($urandom_range(0, 4095));
            endcase
            send_beat(FUNC_QUERY, SEL_W'($urandom), rand64(), rand64(), rand64(), qval);
            items_sent++;
         end
         phase++;
      end

      // drain and verdict
      req_push <= 1'b0;
      @(posedge clock);
      wait (owed_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/crr_pkg.sv
hw/rtl/crr_ram.sv
hw/rtl/crr_front.sv
hw/rtl/crr_back.sv
hw/rtl/chained_range_remap.sv
hw/rtl/crr_checker.sv
tb/remap_checker.sv
tb/tb_top.sv
